[design/rsbod_pkg.sv]
package rsbod_pkg;

  // Scan geometry
  localparam int MAX_BEAMS       = 1024;
  localparam int BOX_HALF_BEAMS  = 28;
  localparam int SIDE_HALF_BEAMS = 158;
  localparam int ROM_N           = BOX_HALF_BEAMS + SIDE_HALF_BEAMS + 1;
  localparam int ROM_AW          = $clog2(ROM_N);

  // Fixed-point constants for the trig table
  localparam longint Q28_ONE       = 64'sd268435456;
  localparam int     Q28_SHIFT     = 28;
  localparam int     Q28_TO_Q15    = 13;
  localparam longint Q15_HALF_LSB  = 64'sd4096;
  localparam longint STEP_Q28      = 64'sd1686634;
  localparam longint BOX_LIMIT_MM  = 64'sd2260;
  localparam longint SIDE_LIMIT_MM = 64'sd400;
  localparam longint LIMIT_CAP     = 64'sd65536;

  // Field widths
  localparam int RANGE_W    = 16;
  localparam int SCAN_LEN_W = 11;
  localparam int CENTER_W   = SCAN_LEN_W - 1;
  localparam int LIM_W      = 17;
  localparam int COS_W      = 16;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_MIN_RANGE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_RANGE   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SCAN_LENGTH = 2'd2;
  localparam logic [CFG_AW-1:0] REG_NO_OBSTACLE = 2'd3;

  // Register reset values
  localparam logic [RANGE_W-1:0]    MIN_RANGE_RST   = 16'd20;
  localparam logic [RANGE_W-1:0]    MAX_RANGE_RST   = 16'd4000;
  localparam logic [SCAN_LEN_W-1:0] SCAN_LENGTH_RST = 11'd1000;
  localparam logic [RANGE_W-1:0]    NO_OBSTACLE_RST = 16'd10000;

  typedef struct packed {
    logic [RANGE_W-1:0]    min_range_mm;
    logic [RANGE_W-1:0]    max_range_mm;
    logic [SCAN_LEN_W-1:0] scan_length;
    logic [RANGE_W-1:0]    no_obstacle_mm;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               range_valid;
    logic               last_beam;
  } beat_t;

  typedef struct packed {
    logic               hit;
    logic [RANGE_W-1:0] proj_mm;
    logic               last_beam;
  } zone_res_t;

  typedef struct packed {
    logic signed [COS_W-1:0] cos15;
    logic [LIM_W-1:0]        box_lim;
    logic [LIM_W-1:0]        side_lim;
  } rom_entry_t;

  typedef rom_entry_t [ROM_N-1:0] rom_t;

  // Truncating quotient of a non-negative numerator and a positive divisor, shift and subtract
  function automatic longint div_trunc(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // Build cos / zone-limit table by Taylor series in Q4.28, evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t   r;
    longint x;
    longint t;
    longint c;
    longint s;
    longint q;
    longint lim;
    bit     done;
    for (int k = 0; k < ROM_N; k++) begin
      x = longint'(k) * STEP_Q28;
      t = Q28_ONE;
      c = Q28_ONE;
      s = 0;
      done = 1'b0;
      for (int n = 1; n <= 40; n++) begin
        if (!done) begin
          t = div_trunc((t * x) >>> Q28_SHIFT, longint'(n));
          if (t == 0) begin
            done = 1'b1;
          end else begin
            case (n & 3)
              1: s = s + t;
              2: c = c - t;
              3: s = s - t;
              default: c = c + t;
            endcase
          end
        end
      end
      q = (c >= 0) ? ((c + Q15_HALF_LSB) >>> Q28_TO_Q15)
                   : -((Q15_HALF_LSB - c) >>> Q28_TO_Q15);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r[k].cos15 = COS_W'(q);
      if (c <= 0) begin
        lim = 0;
      end else begin
        lim = div_trunc(BOX_LIMIT_MM * Q28_ONE + c - 1, c);
        if (lim > LIMIT_CAP) lim = LIMIT_CAP;
      end
      r[k].box_lim = LIM_W'(lim);
      if (s <= 0) begin
        lim = 0;
      end else begin
        lim = div_trunc(SIDE_LIMIT_MM * Q28_ONE + s - 1, s);
        if (lim > LIMIT_CAP) lim = LIMIT_CAP;
      end
      r[k].side_lim = LIM_W'(lim);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

endpackage

[design/rsbod_zone.sv]
module rsbod_zone #(
  parameter int MAX_BEAMS = rsbod_pkg::MAX_BEAMS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rsbod_pkg::cfg_t              cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rsbod_pkg::beat_t             in_beat,
  input  logic [$clog2(MAX_BEAMS)-1:0] in_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rsbod_pkg::zone_res_t         out_res
);

  localparam int IW = $clog2(MAX_BEAMS);
  localparam int OW = ((IW > rsbod_pkg::CENTER_W) ? IW : rsbod_pkg::CENTER_W) + 2;
  localparam logic signed [OW-1:0] BOX_O  = OW'(rsbod_pkg::BOX_HALF_BEAMS);
  localparam logic signed [OW-1:0] SIDE_O = OW'(rsbod_pkg::SIDE_HALF_BEAMS);
  localparam int PROD_W = rsbod_pkg::RANGE_W + rsbod_pkg::COS_W - 1;

  logic signed [OW-1:0]                 offset;
  logic signed [OW-1:0]                 offset_abs;
  logic                                 in_window;
  logic                                 box_zone;
  logic                                 side_zone;
  logic [rsbod_pkg::ROM_AW-1:0]         rom_idx;
  rsbod_pkg::rom_entry_t                rom_q;
  logic [rsbod_pkg::LIM_W-1:0]          lim;
  logic                                 hit;
  logic [PROD_W-1:0]                    prod;
  logic [PROD_W-1:0]                    rounded;
  logic [rsbod_pkg::RANGE_W-1:0]        proj_mm;
  rsbod_pkg::zone_res_t                 res_next;

  // Signed offset from the center beam
  always_comb begin
    offset = signed'(OW'(in_index))
           - signed'(OW'(cfg.scan_length[rsbod_pkg::SCAN_LEN_W-1:1]));
    offset_abs = (offset < 0) ? -offset : offset;
  end

  // Classify by zone and look up the limit
  always_comb begin
    in_window = in_beat.range_valid
              && (in_beat.range_mm > cfg.min_range_mm)
              && (in_beat.range_mm < cfg.max_range_mm);
    box_zone  = (offset > -BOX_O) && (offset <= BOX_O);
    side_zone = ((offset >= -SIDE_O) && (offset <= -BOX_O))
              || ((offset > BOX_O) && (offset <= SIDE_O));
    rom_idx   = (box_zone || side_zone) ? offset_abs[rsbod_pkg::ROM_AW-1:0] : '0;
    rom_q     = rsbod_pkg::ROM[rom_idx];
    lim       = box_zone ? rom_q.box_lim : (side_zone ? rom_q.side_lim : '0);
    hit       = in_window && ({1'b0, in_beat.range_mm} < lim);
  end

  // Project onto the axis: round range * cos
  always_comb begin
    prod    = PROD_W'(in_beat.range_mm) * PROD_W'(rom_q.cos15[rsbod_pkg::COS_W-2:0]);
    rounded = (prod + PROD_W'(16384)) >> 15;
    if (rom_q.cos15 <= 0) begin
      proj_mm = '0;
    end else if (rounded > PROD_W'(16'hFFFF)) begin
      proj_mm = 16'hFFFF;
    end else begin
      proj_mm = rounded[rsbod_pkg::RANGE_W-1:0];
    end
    res_next.hit       = hit;
    res_next.proj_mm   = proj_mm;
    res_next.last_beam = in_beat.last_beam;
  end

  assign in_ready = !out_valid || out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

[design/rsbod_min.sv]
module rsbod_min (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rsbod_pkg::RANGE_W-1:0] no_obstacle_mm,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsbod_pkg::zone_res_t          in_res,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,  // [15:0] nearest_mm
  output logic                          m_tuser   // [0] obstacle_seen
);

  logic                          found;
  logic [rsbod_pkg::RANGE_W-1:0] nearest;
  logic                          found_next;
  logic [rsbod_pkg::RANGE_W-1:0] nearest_next;
  logic                          move;

  // Non-last beats always drain; a last beat waits for a free output slot
  assign in_ready = !in_res.last_beam || !m_tvalid || m_tready;
  assign move     = in_valid && in_ready;

  // Fold this beat into the running minimum
  always_comb begin
    found_next   = found;
    nearest_next = nearest;
    if (in_res.hit && (!found || in_res.proj_mm < nearest)) begin
      found_next   = 1'b1;
      nearest_next = in_res.proj_mm;
    end
  end

  // Running minimum; clear after the last beam
  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      nearest <= '0;
    end else if (move) begin
      if (in_res.last_beam) begin
        found   <= 1'b0;
        nearest <= '0;
      end else begin
        found   <= found_next;
        nearest <= nearest_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move && in_res.last_beam) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move && in_res.last_beam) begin
      m_tdata <= found_next ? nearest_next : no_obstacle_mm;
      m_tuser <= found_next;
    end
  end

endmodule

[design/rear_scan_box_obstacle_distance_core.sv]
// Channel   Dir  Beat contents
// s_*       in   tdata[15:0] range_mm, tuser[0] range_valid, tlast last_beam
// m_*       out  tdata[15:0] nearest_mm, tuser[0] obstacle_seen (one beat per scan)
// cfg_*     in   write enable, register index, 16-bit write data
//
// One beam is taken every cycle unless a waiting result stalls the input; a last beam passes
// the input register, the zone/ROM/multiply register, then the minimum and output register.
// Reset is synchronous; it clears control state and loads the configuration registers with their reset values.
// A waiting result stalls only a following last beam, which then holds the beams behind it.
module rear_scan_box_obstacle_distance_core #(
  parameter int MAX_BEAMS = rsbod_pkg::MAX_BEAMS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // [15:0] range_mm
  input  logic                         s_tuser,   // [0] range_valid
  input  logic                         s_tlast,   // last_beam
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,   // [15:0] nearest_mm
  output logic                         m_tuser,   // [0] obstacle_seen
  input  logic                         cfg_we,
  input  logic [rsbod_pkg::CFG_AW-1:0] cfg_index,
  input  logic [rsbod_pkg::CFG_DW-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_BEAMS);
  localparam logic [IW-1:0] INDEX_MAX = IW'(MAX_BEAMS - 1);

  rsbod_pkg::cfg_t      cfg;
  logic [IW-1:0]        beam_index;
  logic                 in_valid;
  rsbod_pkg::beat_t     in_beat;
  logic [IW-1:0]        in_index;
  logic                 zone_ready;
  logic                 zone_valid;
  rsbod_pkg::zone_res_t zone_res;
  logic                 min_ready;
  logic                 accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range_mm   <= rsbod_pkg::MIN_RANGE_RST;
      cfg.max_range_mm   <= rsbod_pkg::MAX_RANGE_RST;
      cfg.scan_length    <= rsbod_pkg::SCAN_LENGTH_RST;
      cfg.no_obstacle_mm <= rsbod_pkg::NO_OBSTACLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsbod_pkg::REG_MIN_RANGE:   cfg.min_range_mm   <= cfg_data;
        rsbod_pkg::REG_MAX_RANGE:   cfg.max_range_mm   <= cfg_data;
        rsbod_pkg::REG_SCAN_LENGTH:
          cfg.scan_length <= cfg_data[rsbod_pkg::SCAN_LEN_W-1:0];
        rsbod_pkg::REG_NO_OBSTACLE: cfg.no_obstacle_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !in_valid || zone_ready;
  assign accept   = s_tvalid && s_tready;

  // Beam counter: restart after a last beam, wrap at the beam capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index <= '0;
    end else if (accept) begin
      if (s_tlast || beam_index == INDEX_MAX) begin
        beam_index <= '0;
      end else begin
        beam_index <= beam_index + IW'(1);
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_beat.range_mm    <= s_tdata;
      in_beat.range_valid <= s_tuser;
      in_beat.last_beam   <= s_tlast;
      in_index            <= beam_index;
    end
  end

  rsbod_zone #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_zone (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (zone_ready),
    .in_beat   (in_beat),
    .in_index  (in_index),
    .out_valid (zone_valid),
    .out_ready (min_ready),
    .out_res   (zone_res)
  );

  rsbod_min u_min (
    .clk            (clk),
    .rst            (rst),
    .no_obstacle_mm (cfg.no_obstacle_mm),
    .in_valid       (zone_valid),
    .in_ready       (min_ready),
    .in_res         (zone_res),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser)
  );

endmodule

[tb/rear_scan_box_obstacle_distance_core_tb.sv]
module rear_scan_box_obstacle_distance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_SCAN   = 1030;

  typedef struct packed {
    logic [15:0] near_mm;
    logic        seen;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [15:0]                  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [15:0]                  m_tdata;
  logic                         m_tuser;
  logic                         cfg_we = 1'b0;
  logic [rsbod_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [rsbod_pkg::CFG_DW-1:0] cfg_data = '0;

  rear_scan_box_obstacle_distance_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Trig table: cos in Q1.15 and the zone range limits, one entry per offset magnitude
  int cos_q15    [rsbod_pkg::ROM_N];
  int box_limit  [rsbod_pkg::ROM_N];
  int side_limit [rsbod_pkg::ROM_N];

  // Predictor copy of the registers and the scan state
  logic [15:0] cfg_min_mm   = rsbod_pkg::MIN_RANGE_RST;
  logic [15:0] cfg_max_mm   = rsbod_pkg::MAX_RANGE_RST;
  logic [10:0] cfg_scan_len = rsbod_pkg::SCAN_LENGTH_RST;
  logic [15:0] cfg_none_mm  = rsbod_pkg::NO_OBSTACLE_RST;
  logic [9:0]  beam_idx     = '0;
  logic [15:0] nearest_run  = '0;
  bit          hit_seen     = 1'b0;

  rsbod_pkg::beat_t beam_q[$];
  scan_result_t     nearest_q[$];

  int beams_loaded   = 0;
  int beams_accepted = 0;
  int scans_loaded   = 0;
  int mismatches     = 0;
  int cycles         = 0;
  bit idle_on        = 1'b0;
  bit beam_taken     = 1'b0;
  int send_gap       = 0;
  int take_gap       = 0;

  function automatic int ceil_limit(longint num, longint den);
    longint q;
    if (den <= 0) return 0;
    q = (num + den - 1) / den;
    if (q > rsbod_pkg::LIMIT_CAP) q = rsbod_pkg::LIMIT_CAP;
    return int'(q);
  endfunction

  // Sum the sine and cosine series in Q4.28 with truncating division
  function automatic void build_trig_table();
    longint ang;
    longint term;
    longint c_q28;
    longint s_q28;
    longint r;
    for (int k = 0; k < rsbod_pkg::ROM_N; k++) begin
      ang   = longint'(k) * rsbod_pkg::STEP_Q28;
      term  = rsbod_pkg::Q28_ONE;
      c_q28 = rsbod_pkg::Q28_ONE;
      s_q28 = 0;
      for (int n = 1; n <= 40 && term != 0; n++) begin
        term = term * ang / rsbod_pkg::Q28_ONE / n;
        if (term != 0) begin
          case (n % 4)
            1: s_q28 += term;
            2: c_q28 -= term;
            3: s_q28 -= term;
            default: c_q28 += term;
          endcase
        end
      end
      r = (c_q28 >= 0) ? (c_q28 + 4096) / 8192 : -((4096 - c_q28) / 8192);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      cos_q15[k]    = int'(r);
      box_limit[k]  = ceil_limit(rsbod_pkg::BOX_LIMIT_MM * rsbod_pkg::Q28_ONE, c_q28);
      side_limit[k] = ceil_limit(rsbod_pkg::SIDE_LIMIT_MM * rsbod_pkg::Q28_ONE, s_q28);
    end
  endfunction

  // Range limit of the zone at this offset from the center beam, -1 outside both zones
  function automatic int zone_limit(int ofs);
    int k;
    k = (ofs < 0) ? -ofs : ofs;
    if (ofs >= -rsbod_pkg::SIDE_HALF_BEAMS && ofs <= -rsbod_pkg::BOX_HALF_BEAMS)
      return side_limit[k];
    if (ofs > -rsbod_pkg::BOX_HALF_BEAMS && ofs <= rsbod_pkg::BOX_HALF_BEAMS)
      return box_limit[k];
    if (ofs > rsbod_pkg::BOX_HALF_BEAMS && ofs <= rsbod_pkg::SIDE_HALF_BEAMS)
      return side_limit[k];
    return -1;
  endfunction

  // Fold one accepted beam into the running minimum; a last beam closes the scan
  function automatic void predict_beam(rsbod_pkg::beat_t b);
    int     ofs;
    int     k;
    longint proj;
    ofs = int'(beam_idx) - int'(cfg_scan_len >> 1);
    if (b.range_valid && b.range_mm > cfg_min_mm && b.range_mm < cfg_max_mm &&
        int'(b.range_mm) < zone_limit(ofs)) begin
      k = (ofs < 0) ? -ofs : ofs;
      proj = 0;
      if (cos_q15[k] > 0)
        proj = (longint'(b.range_mm) * cos_q15[k] + 16384) >>> 15;
      if (proj > 65535) proj = 65535;
      if (!hit_seen || proj < nearest_run) begin
        nearest_run = 16'(proj);
        hit_seen    = 1'b1;
      end
    end
    if (b.last_beam) begin
      nearest_q.push_back('{hit_seen ? nearest_run : cfg_none_mm, hit_seen});
      beam_idx    = '0;
      nearest_run = '0;
      hit_seen    = 1'b0;
    end else begin
      beam_idx = beam_idx + 10'd1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sample both channels; check results before folding in the new beam
  always @(posedge clk) begin : monitor
    scan_result_t want;
    beam_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch("unexpected result, nearest_mm", int'(m_tdata), -1);
        end else begin
          want = nearest_q.pop_front();
          if (m_tdata !== want.near_mm)
            report_mismatch("nearest_mm", int'(m_tdata), int'(want.near_mm));
          if (m_tuser !== want.seen)
            report_mismatch("obstacle_seen", int'(m_tuser), int'(want.seen));
        end
      end
      if (s_tvalid && s_tready) begin
        beam_taken = 1'b1;
        beams_accepted++;
        predict_beam(rsbod_pkg::beat_t'({s_tdata, s_tuser, s_tlast}));
      end
    end
  end

  // Beam driver: hold a beat until taken, then idle in bursts or send the next one
  always @(negedge clk) begin : beam_driver
    rsbod_pkg::beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beam_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 16);
        s_tvalid <= 1'b0;
      end else if (beam_q.size() != 0) begin
        nxt = beam_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.range_mm;
        s_tuser  <= nxt.range_valid;
        s_tlast  <= nxt.last_beam;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stall in random bursts
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap <= take_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      take_gap <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [rsbod_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsbod_pkg::REG_MIN_RANGE:   cfg_min_mm   = val;
      rsbod_pkg::REG_MAX_RANGE:   cfg_max_mm   = val;
      rsbod_pkg::REG_SCAN_LENGTH: cfg_scan_len = val[10:0];
      rsbod_pkg::REG_NO_OBSTACLE: cfg_none_mm  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] min_mm, input logic [15:0] max_mm,
                            input logic [15:0] len_word, input logic [15:0] none_mm);
    write_reg(rsbod_pkg::REG_MIN_RANGE, min_mm);
    write_reg(rsbod_pkg::REG_MAX_RANGE, max_mm);
    write_reg(rsbod_pkg::REG_SCAN_LENGTH, len_word);
    write_reg(rsbod_pkg::REG_NO_OBSTACLE, none_mm);
  endtask

  task automatic load_beam(input logic [15:0] range_mm, input logic valid, input logic last);
    beam_q.push_back('{range_mm, valid, last});
    beams_loaded++;
    if (last) scans_loaded++;
  endtask

  // Bias ranges toward the register edges and the zone limit of this beam
  function automatic logic [15:0] pick_range(int ofs);
    int lim;
    lim = zone_limit(ofs);
    case ($urandom_range(0, 11))
      0: return 16'($urandom);
      1: return cfg_min_mm;
      2: return cfg_min_mm + 16'd1;
      3: return cfg_max_mm;
      4: return cfg_max_mm - 16'd1;
      5: return (lim > 0) ? 16'(lim - 1) : 16'($urandom);
      6: return (lim > 0) ? 16'(lim) : 16'($urandom);
      default: return 16'($urandom_range(1, 2600));
    endcase
  endfunction

  task automatic load_scan(input int n);
    for (int j = 0; j < n; j++)
      load_beam(pick_range((j % rsbod_pkg::MAX_BEAMS) - int'(cfg_scan_len >> 1)),
                $urandom_range(0, 9) != 0, j == n - 1);
  endtask

  // Mostly scans of the configured length, some cut short or running past the zones
  task automatic load_scans(input int budget);
    int stop_at;
    int n;
    stop_at = beams_loaded + budget;
    while (beams_loaded < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: n = $urandom_range(1, 200);
        2: n = $urandom_range(1, 8);
        default: n = (cfg_scan_len == 0) ? 1 : int'(cfg_scan_len);
      endcase
      load_scan(n);
    end
  endtask

  // Wait for every beat to be taken and every result to come back, then let the pipe empty
  task automatic drain();
    while (beams_accepted != beams_loaded || nearest_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    build_trig_table();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: center at beam 2, register edges, invalid beams, zone limits
    set_config(16'd20, 16'd4000, 16'd4, 16'd10000);
    load_beam(16'd1000, 1'b1, 1'b0);
    load_beam(16'd0, 1'b1, 1'b0);
    load_beam(16'hFFFF, 1'b0, 1'b0);
    load_beam(16'd20, 1'b1, 1'b0);
    load_beam(16'd4000, 1'b1, 1'b0);
    load_beam(16'd21, 1'b1, 1'b1);
    load_beam(16'd500, 1'b0, 1'b1);
    load_beam(16'hFFFF, 1'b1, 1'b1);
    load_beam(16'd3999, 1'b1, 1'b0);
    load_beam(16'(box_limit[1] - 1), 1'b1, 1'b0);
    load_beam(16'(box_limit[0]), 1'b1, 1'b0);
    load_beam(16'(box_limit[1]), 1'b1, 1'b0);
    load_beam(16'd2000, 1'b1, 1'b0);
    load_beam(16'd1999, 1'b1, 1'b1);
    drain();

    idle_on = 1'b1;
    // Widest window, center at beam zero
    set_config(16'd0, 16'hFFFF, 16'd0, 16'd0);
    load_scans(150);
    drain();
    // Empty window: nothing can count
    set_config(16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    load_scans(60);
    drain();
    // Largest scan length, one scan long enough to wrap the beam counter
    set_config(16'd100, 16'd3000, 16'hFFFF, 16'd1234);
    load_scan(LONG_SCAN);
    drain();

    while (beams_loaded < 1800 || scans_loaded < 60) begin
      set_config(16'($urandom_range(0, 200)), 16'($urandom_range(1500, 65535)),
                 16'($urandom_range(0, 60)), 16'($urandom));
      load_scans(120);
      drain();
    end

    // Closing stretch at full rate on both sides
    idle_on = 1'b0;
    set_config(16'd20, 16'd4000, 16'd57, 16'd10000);
    load_scans(150);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
